// ===== hw/rtl/brainfuck_interpreter_core_macros.svh =====
// Assertion helpers for the checker file.
`ifndef BRAINFUCK_INTERPRETER_CORE_MACROS_SVH
`define BRAINFUCK_INTERPRETER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BFI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bfi_pkg.sv =====
package bfi_pkg;

  localparam int unsigned PROG_DEPTH = 1024;
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned NEST_DEPTH = 64;

  // program address, length / pc, tape address, stack index, stack count
  localparam int unsigned PA = $clog2(PROG_DEPTH);
  localparam int unsigned LW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TA = $clog2(TAPE_DEPTH);
  localparam int unsigned SA = $clog2(NEST_DEPTH);
  localparam int unsigned SW = $clog2(NEST_DEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FINISHED  = 3'd1;
  localparam logic [2:0] ST_UNDER     = 3'd2;
  localparam logic [2:0] ST_OVER      = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd6;

  localparam logic [7:0] CH_INC   = 8'h2B; // +
  localparam logic [7:0] CH_DEC   = 8'h2D; // -
  localparam logic [7:0] CH_LEFT  = 8'h3C; // <
  localparam logic [7:0] CH_RIGHT = 8'h3E; // >
  localparam logic [7:0] CH_OUT   = 8'h2E; // .
  localparam logic [7:0] CH_IN    = 8'h2C; // ,
  localparam logic [7:0] CH_OPEN  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE = 8'h5D; // ]

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_INC   = 4'd1,
    OP_DEC   = 4'd2,
    OP_LEFT  = 4'd3,
    OP_RIGHT = 4'd4,
    OP_OUT   = 4'd5,
    OP_IN    = 4'd6,
    OP_OPEN  = 4'd7,
    OP_CLOSE = 4'd8
  } op_e;

  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
    logic       is_last;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       input_taken;
    logic [2:0] status;
  } out_item_t;

  // load unit -> control
  typedef struct packed {
    logic [LW-1:0] len;
    logic [SW-1:0] top;
    logic [2:0]    status;
    logic          load_done;
    logic          prog_we;
    logic [PA-1:0] pos;
    op_e           op;
    logic          push;
    logic          link;
    logic [PA-1:0] partner_pos;
  } load_res_t;

  // step unit -> control
  typedef struct packed {
    logic [LW-1:0] pc;
    logic [TA-1:0] ptr;
    logic [2:0]    status;
    logic          tape_we;
    logic [7:0]    tape_wdata;
    logic          out_valid;
    logic [7:0]    out_byte;
    logic          input_taken;
  } step_res_t;

  function automatic op_e encode_symbol(input logic [7:0] c);
    op_e op;
    unique case (c)
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_LEFT:  op = OP_LEFT;
      CH_RIGHT: op = OP_RIGHT;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/bfi_ram.sv =====
module bfi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bfi_load.sv =====
module bfi_load (
  input  logic                  load_done_i,
  input  logic [bfi_pkg::LW-1:0] len_i,
  input  logic [bfi_pkg::SW-1:0] top_i,
  input  logic [2:0]            status_i,
  input  logic [7:0]            symbol_i,
  input  logic                  is_last_i,
  input  logic [bfi_pkg::PA-1:0] stack_rdata_i,
  output bfi_pkg::load_res_t    res_o
);
  import bfi_pkg::*;

  logic [LW-1:0] len_e;
  logic [SW-1:0] top_e;
  logic [2:0]    st_e;

  // a load after the final symbol opens a new program
  assign len_e = load_done_i ? '0 : len_i;
  assign top_e = load_done_i ? '0 : top_i;
  assign st_e  = load_done_i ? ST_OK : status_i;

  always_comb begin
    res_o             = '0;
    res_o.len         = len_e;
    res_o.top         = top_e;
    res_o.status      = st_e;
    res_o.load_done   = is_last_i;
    res_o.pos         = len_e[PA-1:0];
    res_o.op          = encode_symbol(symbol_i);
    res_o.partner_pos = stack_rdata_i;
    if (st_e == ST_OK) begin
      if (len_e >= LW'(PROG_DEPTH)) begin
        res_o.status = ST_TOO_LONG;
      end else begin
        case (res_o.op)
          OP_OPEN: begin
            if (top_e == SW'(NEST_DEPTH)) begin
              res_o.status = ST_TOO_DEEP;
            end else begin
              res_o.push = 1'b1;
              res_o.top  = top_e + SW'(1);
            end
          end
          OP_CLOSE: begin
            if (top_e == '0) begin
              res_o.status = ST_UNMATCHED;
            end else begin
              res_o.link = 1'b1;
              res_o.top  = top_e - SW'(1);
            end
          end
          default: ;
        endcase
        if (res_o.status == ST_OK) begin
          res_o.prog_we = 1'b1;
          res_o.len     = len_e + LW'(1);
        end
      end
    end
    if (is_last_i && res_o.status == ST_OK && res_o.top != '0) begin
      res_o.status = ST_UNMATCHED;
    end
  end

endmodule

// ===== hw/rtl/bfi_step.sv =====
module bfi_step (
  input  logic                   load_done_i,
  input  logic [2:0]             status_i,
  input  logic [bfi_pkg::LW-1:0] pc_i,
  input  logic [bfi_pkg::LW-1:0] len_i,
  input  logic [bfi_pkg::TA-1:0] ptr_i,
  input  bfi_pkg::op_e           op_i,
  input  logic [7:0]             cell_i,
  input  logic [bfi_pkg::PA-1:0] match_i,
  input  logic [7:0]             in_byte_i,
  output bfi_pkg::step_res_t     res_o
);
  import bfi_pkg::*;

  logic [LW-1:0] nxt;
  logic          hold;

  always_comb begin
    res_o            = '0;
    res_o.pc         = pc_i;
    res_o.ptr        = ptr_i;
    res_o.status     = status_i;
    res_o.tape_wdata = cell_i;
    nxt              = pc_i + LW'(1);
    hold             = 1'b0;
    if (!load_done_i || status_i != ST_OK) begin
      // halted or still loading: report only
    end else if (pc_i >= len_i) begin
      res_o.status = ST_FINISHED;
    end else begin
      case (op_i)
        OP_INC: begin
          res_o.tape_we    = 1'b1;
          res_o.tape_wdata = cell_i + 8'd1;
        end
        OP_DEC: begin
          res_o.tape_we    = 1'b1;
          res_o.tape_wdata = cell_i - 8'd1;
        end
        OP_LEFT: begin
          if (ptr_i == '0) begin
            res_o.status = ST_UNDER;
            hold         = 1'b1;
          end else begin
            res_o.ptr = ptr_i - TA'(1);
          end
        end
        OP_RIGHT: begin
          if (ptr_i == TA'(TAPE_DEPTH - 1)) begin
            res_o.status = ST_OVER;
            hold         = 1'b1;
          end else begin
            res_o.ptr = ptr_i + TA'(1);
          end
        end
        OP_OUT: begin
          res_o.out_valid = 1'b1;
          res_o.out_byte  = cell_i;
        end
        OP_IN: begin
          res_o.tape_we     = 1'b1;
          res_o.tape_wdata  = in_byte_i;
          res_o.input_taken = 1'b1;
        end
        OP_OPEN: begin
          if (cell_i == 8'd0) nxt = LW'(match_i) + LW'(1);
        end
        OP_CLOSE: begin
          if (cell_i != 8'd0) nxt = LW'(match_i) + LW'(1);
        end
        default: ;
      endcase
      if (!hold) begin
        res_o.pc = nxt;
        if (nxt >= len_i) res_o.status = ST_FINISHED;
      end
    end
  end

endmodule

// ===== hw/rtl/brainfuck_interpreter_core.sv =====
// Sequence: an accepted input beat is held in item_q, handled in EXEC and handed
//   on in RESP; a matched closing bracket while loading also passes MATCH (two
//   match table writes), and RESP waits while the output register stays full.
// Flow: no new input item is taken until the last one's result is handed on; the
//   tape and program stores each have one write and one registered read port.
// Reset: asynchronous, active low; then a clearing pass writes zero to every tape
//   cell (TAPE_DEPTH, 32768), with in_ready_o low until it ends.
module brainfuck_interpreter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfi_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bfi_pkg::out_item_t out_data_o
);
  import bfi_pkg::*;

  // Control sequence:
  //   CLEAR : tape sweep after reset
  //   IDLE  : wait for an input beat; registered reads of all stores run every
  //           cycle off pc_q / ptr_q / top_q, so data is ready in EXEC
  //   EXEC  : load or step decision, store writes, result formed
  //   MATCH : second match table write for a closing bracket
  //   RESP  : hand result to the output register once it is free
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MATCH = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [TA-1:0] clr_q, clr_d;
  logic [LW-1:0] len_q, len_d;
  logic [SW-1:0] top_q, top_d;
  logic [LW-1:0] pc_q, pc_d;
  logic [TA-1:0] ptr_q, ptr_d;
  logic [2:0]    status_q, status_d;
  logic          load_done_q, load_done_d;
  logic          out_valid_q, out_valid_d;

  // payload registers, no reset
  in_item_t      item_q, item_d;
  out_item_t     res_q, res_d;
  out_item_t     out_q, out_d;
  logic [PA-1:0] mpos_q, mpos_d;
  logic [PA-1:0] mopen_q, mopen_d;

  // store ports
  logic          prog_we;
  logic [3:0]    prog_rdata;
  logic          match_we;
  logic [PA-1:0] match_waddr, match_wdata, match_rdata;
  logic          stack_we;
  logic [PA-1:0] stack_rdata;
  logic          tape_we;
  logic [TA-1:0] tape_waddr;
  logic [7:0]    tape_wdata, tape_rdata;

  load_res_t     ld;
  step_res_t     st;

  // Program store: 4-bit opcodes, written at the load position, read at pc.
  bfi_ram #(.WIDTH(4), .DEPTH(PROG_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (ld.pos),
    .wdata_i (ld.op),
    .raddr_i (pc_q[PA-1:0]),
    .rdata_o (prog_rdata)
  );

  // Match table: jump partner of each bracket, read at pc alongside the opcode.
  bfi_ram #(.WIDTH(PA), .DEPTH(PROG_DEPTH)) u_match (
    .clk_i   (clk_i),
    .we_i    (match_we),
    .waddr_i (match_waddr),
    .wdata_i (match_wdata),
    .raddr_i (pc_q[PA-1:0]),
    .rdata_o (match_rdata)
  );

  // Bracket stack: push at top, the read port always shows the entry under top.
  bfi_ram #(.WIDTH(PA), .DEPTH(NEST_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (ld.top[SA-1:0] - (ld.push ? SA'(1) : SA'(0))),
    .wdata_i (ld.pos),
    .raddr_i (SA'(top_q - SW'(1))),
    .rdata_o (stack_rdata)
  );

  // Tape: read at the pointer, written back by the step or the clearing sweep.
  bfi_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (ptr_q),
    .rdata_o (tape_rdata)
  );

  bfi_load u_load (
    .load_done_i   (load_done_q),
    .len_i         (len_q),
    .top_i         (top_q),
    .status_i      (status_q),
    .symbol_i      (item_q.symbol),
    .is_last_i     (item_q.is_last),
    .stack_rdata_i (stack_rdata),
    .res_o         (ld)
  );

  bfi_step u_step (
    .load_done_i (load_done_q),
    .status_i    (status_q),
    .pc_i        (pc_q),
    .len_i       (len_q),
    .ptr_i       (ptr_q),
    .op_i        (op_e'(prog_rdata)),
    .cell_i      (tape_rdata),
    .match_i     (match_rdata),
    .in_byte_i   (item_q.in_byte),
    .res_o       (st)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    len_d       = len_q;
    top_d       = top_q;
    pc_d        = pc_q;
    ptr_d       = ptr_q;
    status_d    = status_q;
    load_done_d = load_done_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    mpos_d      = mpos_q;
    mopen_d     = mopen_q;
    prog_we     = 1'b0;
    match_we    = 1'b0;
    match_waddr = ld.partner_pos;
    match_wdata = ld.pos;
    stack_we    = 1'b0;
    tape_we     = 1'b0;
    tape_waddr  = ptr_q;
    tape_wdata  = st.tape_wdata;

    // output register drains independently of the sequence
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = '0;
        clr_d      = clr_q + TA'(1);
        if (clr_q == TA'(TAPE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        if (item_q.command == CMD_LOAD) begin
          len_d       = ld.len;
          top_d       = ld.top;
          status_d    = ld.status;
          load_done_d = ld.load_done;
          prog_we     = ld.prog_we;
          stack_we    = ld.push;
          if (load_done_q) begin
            pc_d  = '0;
            ptr_d = '0;
          end
          res_d        = '0;
          res_d.status = ld.status;
          if (ld.link) begin
            // forward link now, backward link next cycle
            match_we = 1'b1;
            mpos_d   = ld.pos;
            mopen_d  = ld.partner_pos;
            state_d  = S_MATCH;
          end
        end else begin
          pc_d              = st.pc;
          ptr_d             = st.ptr;
          status_d          = st.status;
          tape_we           = st.tape_we;
          res_d.out_valid   = st.out_valid;
          res_d.out_byte    = st.out_byte;
          res_d.input_taken = st.input_taken;
          res_d.status      = st.status;
        end
      end
      S_MATCH: begin
        match_we    = 1'b1;
        match_waddr = mpos_q;
        match_wdata = mopen_q;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      len_q       <= '0;
      top_q       <= '0;
      pc_q        <= '0;
      ptr_q       <= '0;
      status_q    <= ST_OK;
      load_done_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      len_q       <= len_d;
      top_q       <= top_d;
      pc_q        <= pc_d;
      ptr_q       <= ptr_d;
      status_q    <= status_d;
      load_done_q <= load_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    res_q   <= res_d;
    out_q   <= out_d;
    mpos_q  <= mpos_d;
    mopen_q <= mopen_d;
  end

endmodule

// ===== hw/rtl/bfi_checker.sv =====
`include "brainfuck_interpreter_core_macros.svh"

module bfi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input bfi_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bfi_pkg::out_item_t out_data_o
);
  import bfi_pkg::*;

  logic in_beat;
  logic out_io;

  assign in_beat = in_valid_i && in_ready_o;
  assign out_io  = out_data_o.out_valid || out_data_o.input_taken;

  `BFI_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i), "input beat dropped or changed while stalled")

  `BFI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")

  `BFI_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_beat, !in_ready_o, "input taken while an item is in progress")

  `BFI_ASSERT_IMPLY(a_io_exclusive, clk_i, rst_ni, out_valid_o, !(out_data_o.out_valid && out_data_o.input_taken), "one step both emitted and consumed a byte")

  `BFI_ASSERT_IMPLY(a_io_status, clk_i, rst_ni, out_valid_o && out_io, out_data_o.status == ST_OK || out_data_o.status == ST_FINISHED, "byte traffic on a halting step")

endmodule

bind brainfuck_interpreter_core bfi_checker u_bfi_checker (.*);
